@@ rtl/core/fbm_pkg.sv @@
// ---------------------------------------------------------------------------
// fbm_pkg
// Shared types, constants and helpers of the fractal value noise core.
// ---------------------------------------------------------------------------
`default_nettype none

package fbm_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned AMP_W   = 17;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned FACT_W  = 16;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned DATA_W  = 32;

  localparam logic [31:0] HASH_MUL_X = 32'h27d4eb2d;
  localparam logic [31:0] HASH_MUL_Y = 32'h165667b1;
  localparam logic [31:0] HASH_MUL_S = 32'h9e3779b9;
  localparam logic [31:0] HASH_MIX_A = 32'h85ebca6b;
  localparam logic [31:0] HASH_MIX_B = 32'hc2b2ae35;
  localparam logic [63:0] OCT_SEED_STEP = 64'd1315423911;

  localparam logic [FREQ_W-1:0] FREQ_ONE = 32'd4096;
  localparam logic [AMP_W-1:0]  AMP_HALF = 17'd32768;
  localparam logic [OUT_W-1:0]  Q_MAX    = 16'd16384;

  localparam logic [31:0]       SEED_RST = 32'd0;
  localparam logic [CNT_W-1:0]  CNT_RST  = 4'd4;
  localparam logic [FACT_W-1:0] LAC_RST  = 16'd8192;
  localparam logic [FACT_W-1:0] GAIN_RST = 16'd8192;

  typedef enum logic [IDX_W-1:0] {
    CFG_SEED   = 8'd0,
    CFG_OCTAVE = 8'd1,
    CFG_LAC    = 8'd2,
    CFG_GAIN   = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]       seed;
    logic [CNT_W-1:0]  octave_count;
    logic [FACT_W-1:0] lacunarity;
    logic [FACT_W-1:0] gain;
  } cfg_t;

  function automatic logic [VAL_W-1:0] lerp(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b,
                                            input logic [WGT_W-1:0] w);
    logic [41:0] s;
    s = 42'(a) * (42'h10000 - 42'(w)) + 42'(b) * 42'(w);
    return s[39:16];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fbm_octave.sv @@
// ---------------------------------------------------------------------------
// fbm_octave
// One octave: scale, lattice hash of four corners, smoothstep blend, and
// weighted accumulation. Seven register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module fbm_octave #(
  parameter int unsigned OCT_IDX         = 0,
  parameter int unsigned COORD_FRAC_BITS = 16,
  parameter int unsigned SUM_W           = 48,
  parameter int unsigned NORM_W          = 21
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire fbm_pkg::cfg_t                   cfg_i,
  input  wire logic                            valid_i,
  input  wire logic [fbm_pkg::COORD_W-1:0]     coord_x_i,
  input  wire logic [fbm_pkg::COORD_W-1:0]     coord_y_i,
  input  wire logic [fbm_pkg::FREQ_W-1:0]      freq_i,
  input  wire logic [fbm_pkg::AMP_W-1:0]       amp_i,
  input  wire logic signed [SUM_W-1:0]         sum_i,
  input  wire logic [NORM_W-1:0]               norm_i,
  output logic                                 valid_o,
  output logic [fbm_pkg::COORD_W-1:0]          coord_x_o,
  output logic [fbm_pkg::COORD_W-1:0]          coord_y_o,
  output logic [fbm_pkg::FREQ_W-1:0]           freq_o,
  output logic [fbm_pkg::AMP_W-1:0]            amp_o,
  output logic signed [SUM_W-1:0]              sum_o,
  output logic [NORM_W-1:0]                    norm_o
);

  localparam int unsigned FB     = COORD_FRAC_BITS;
  localparam int unsigned NSTG   = 7;
  localparam int unsigned CW     = fbm_pkg::COORD_W;
  localparam int unsigned AW     = fbm_pkg::AMP_W;
  localparam int unsigned CAR_W  = 2 * CW + fbm_pkg::FREQ_W + 2 * AW + 1 + SUM_W + NORM_W;
  localparam int unsigned O_NORM = 0;
  localparam int unsigned O_SUM  = O_NORM + NORM_W;
  localparam int unsigned O_ACT  = O_SUM + SUM_W;
  localparam int unsigned O_AMP  = O_ACT + 1;
  localparam int unsigned O_AMPN = O_AMP + AW;
  localparam int unsigned O_FRQN = O_AMPN + AW;
  localparam int unsigned O_Y    = O_FRQN + fbm_pkg::FREQ_W;
  localparam int unsigned O_X    = O_Y + CW;
  localparam logic [31:0] OCT_SEED = 32'(64'(OCT_IDX) * fbm_pkg::OCT_SEED_STEP);

  logic              v_q   [NSTG];
  logic [CAR_W-1:0]  car_q [NSTG];
  logic [CAR_W-1:0]  car_d;

  logic [47:0] fprod;
  logic [32:0] aprod;
  logic [31:0] freq_nxt;
  logic [AW-1:0] amp_nxt;

  always_comb begin
    fprod    = 48'(freq_i) * 48'(cfg_i.lacunarity);
    aprod    = 33'(amp_i) * 33'(cfg_i.gain);
    freq_nxt = (fprod[47:44] != 4'd0) ? 32'hFFFF_FFFF : fprod[43:12];
    amp_nxt  = (aprod[32:31] != 2'd0) ? {AW{1'b1}} : aprod[30:14];
    car_d    = {coord_x_i, coord_y_i, freq_nxt, amp_nxt, amp_i,
                (32'(cfg_i.octave_count) > OCT_IDX), sum_i, norm_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < NSTG; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      car_q[0] <= car_d;
      for (int i = 1; i < NSTG; i++) car_q[i] <= car_q[i-1];
    end
  end

  // stage 1
  logic signed [64:0] px1_q, py1_q;
  logic [31:0]        hs1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px1_q <= $signed(coord_x_i) * $signed({1'b0, freq_i});
      py1_q <= $signed(coord_y_i) * $signed({1'b0, freq_i});
      hs1_q <= (cfg_i.seed + OCT_SEED) * fbm_pkg::HASH_MUL_S;
    end
  end

  // stage 2
  logic [67:0]      pxe, pye;
  logic [31:0]      cx, cy;
  logic [FB+15:0]   fxw, fyw;
  logic [15:0]      tx, ty;
  logic [31:0]      hx0_q, hx1_q, hy0_q, hy1_q, hs2_q, ttx2_q, tty2_q;
  logic [15:0]      tx2_q, ty2_q;

  always_comb begin
    pxe = {{3{px1_q[64]}}, px1_q};
    pye = {{3{py1_q[64]}}, py1_q};
    cx  = pxe[FB+43:FB+12];
    cy  = pye[FB+43:FB+12];
    fxw = {pxe[FB+11:12], 16'h0};
    fyw = {pye[FB+11:12], 16'h0};
    tx  = fxw[FB+15:FB];
    ty  = fyw[FB+15:FB];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hx0_q  <= cx * fbm_pkg::HASH_MUL_X;
      hx1_q  <= (cx + 32'd1) * fbm_pkg::HASH_MUL_X;
      hy0_q  <= cy * fbm_pkg::HASH_MUL_Y;
      hy1_q  <= (cy + 32'd1) * fbm_pkg::HASH_MUL_Y;
      hs2_q  <= hs1_q;
      tx2_q  <= tx;
      ty2_q  <= ty;
      ttx2_q <= 32'(tx) * 32'(tx);
      tty2_q <= 32'(ty) * 32'(ty);
    end
  end

  // stage 3
  logic [31:0] h0 [4];
  logic [31:0] m3_q [4];
  logic [49:0] sx3_q, sy3_q;

  always_comb begin
    h0[0] = hx0_q ^ hy0_q ^ hs2_q;
    h0[1] = hx1_q ^ hy0_q ^ hs2_q;
    h0[2] = hx0_q ^ hy1_q ^ hs2_q;
    h0[3] = hx1_q ^ hy1_q ^ hs2_q;
    for (int i = 0; i < 4; i++) h0[i] = h0[i] ^ (h0[i] >> 15);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) m3_q[i] <= h0[i] * fbm_pkg::HASH_MIX_A;
      sx3_q <= 50'(ttx2_q) * (50'd196608 - 50'({tx2_q, 1'b0}));
      sy3_q <= 50'(tty2_q) * (50'd196608 - 50'({ty2_q, 1'b0}));
    end
  end

  // stage 4
  logic [31:0] h1 [4];
  logic [31:0] m4_q [4];
  logic [15:0] u4_q, w4_q;

  always_comb begin
    for (int i = 0; i < 4; i++) h1[i] = m3_q[i] ^ (m3_q[i] >> 13);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) m4_q[i] <= h1[i] * fbm_pkg::HASH_MIX_B;
      u4_q <= sx3_q[47:32];
      w4_q <= sy3_q[47:32];
    end
  end

  // stage 5
  logic [31:0] h2 [4];
  logic [23:0] r0_5_q, r1_5_q;
  logic [15:0] w5_q;

  always_comb begin
    for (int i = 0; i < 4; i++) h2[i] = m4_q[i] ^ (m4_q[i] >> 16);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_5_q <= fbm_pkg::lerp(h2[0][23:0], h2[1][23:0], u4_q);
      r1_5_q <= fbm_pkg::lerp(h2[2][23:0], h2[3][23:0], u4_q);
      w5_q   <= w4_q;
    end
  end

  // stage 6
  logic [23:0] r6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) r6_q <= fbm_pkg::lerp(r0_5_q, r1_5_q, w5_q);
  end

  // stage 7
  logic signed [25:0] nval;
  logic signed [43:0] term;
  logic [CAR_W-1:0]   c6;
  logic signed [SUM_W-1:0] sum7_q;
  logic [NORM_W-1:0]       norm7_q;

  always_comb begin
    c6   = car_q[5];
    nval = $signed({1'b0, r6_q, 1'b0}) - 26'sd16777216;
    term = $signed({1'b0, c6[O_AMP +: AW]}) * nval;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (c6[O_ACT]) begin
        sum7_q  <= $signed(c6[O_SUM +: SUM_W]) + SUM_W'(term);
        norm7_q <= c6[O_NORM +: NORM_W] + NORM_W'(c6[O_AMP +: AW]);
      end else begin
        sum7_q  <= $signed(c6[O_SUM +: SUM_W]);
        norm7_q <= c6[O_NORM +: NORM_W];
      end
    end
  end

  assign valid_o   = v_q[NSTG-1];
  assign coord_x_o = car_q[NSTG-1][O_X +: CW];
  assign coord_y_o = car_q[NSTG-1][O_Y +: CW];
  assign freq_o    = car_q[NSTG-1][O_FRQN +: fbm_pkg::FREQ_W];
  assign amp_o     = car_q[NSTG-1][O_AMPN +: AW];
  assign sum_o     = sum7_q;
  assign norm_o    = norm7_q;

endmodule

`default_nettype wire

@@ rtl/core/fbm_div.sv @@
// ---------------------------------------------------------------------------
// fbm_div
// Normalize: restoring divide of |sum| by norm * 2^10, one quotient bit per
// stage, then clamp and sign; a zero norm gives zero. Nineteen register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module fbm_div #(
  parameter int unsigned SUM_W  = 48,
  parameter int unsigned NORM_W = 21
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic signed [SUM_W-1:0]       sum_i,
  input  wire logic [NORM_W-1:0]             norm_i,
  output logic                               valid_o,
  output logic [fbm_pkg::OUT_W-1:0]          value_o
);

  localparam int unsigned DEN_W = NORM_W + 10;
  localparam int unsigned CW    = (SUM_W > DEN_W + 17) ? SUM_W : DEN_W + 17;
  localparam int unsigned NB    = 16;

  logic              v_q    [NB+2];
  logic [CW-1:0]     rem_q  [NB+2];
  logic [NB-1:0]     quo_q  [NB+2];
  logic [DEN_W-1:0]  den_q  [NB+2];
  logic              neg_q  [NB+2];
  logic              zero_q [NB+2];
  logic              ovf_q  [NB+2];

  logic [SUM_W-1:0] mag;

  assign mag = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NB + 2; i++) v_q[i] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < NB + 2; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= CW'(mag);
      quo_q[0]  <= '0;
      den_q[0]  <= {norm_i, 10'd0};
      neg_q[0]  <= sum_i[SUM_W-1];
      zero_q[0] <= (norm_i == '0);
      ovf_q[0]  <= 1'b0;
      rem_q[1]  <= rem_q[0];
      quo_q[1]  <= quo_q[0];
      den_q[1]  <= den_q[0];
      neg_q[1]  <= neg_q[0];
      zero_q[1] <= zero_q[0];
      ovf_q[1]  <= (rem_q[0] >= (CW'(den_q[0]) << NB));
    end
  end

  for (genvar j = 2; j < NB + 2; j++) begin : g_bit
    localparam int unsigned K = NB + 1 - j;
    logic [CW-1:0] shf;
    logic          ge;
    assign shf = CW'(den_q[j-1]) << K;
    assign ge  = (rem_q[j-1] >= shf);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? rem_q[j-1] - shf : rem_q[j-1];
        quo_q[j]  <= quo_q[j-1] | (ge ? (NB'(1) << K) : '0);
        den_q[j]  <= den_q[j-1];
        neg_q[j]  <= neg_q[j-1];
        zero_q[j] <= zero_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
      end
    end
  end

  logic [fbm_pkg::OUT_W-1:0] qm, val_d, val_q;
  logic                      vout_q;

  always_comb begin
    qm = (ovf_q[NB+1] || (quo_q[NB+1] > fbm_pkg::Q_MAX)) ? fbm_pkg::Q_MAX : quo_q[NB+1];
    if (zero_q[NB+1]) val_d = '0;
    else if (neg_q[NB+1]) val_d = -qm;
    else val_d = qm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en_i) begin
      vout_q <= v_q[NB+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) val_q <= val_d;
  end

  assign valid_o = vout_q;
  assign value_o = val_q;

endmodule

`default_nettype wire

@@ rtl/core/fbm_value_noise_2d_core.sv @@
// ---------------------------------------------------------------------------
// fbm_value_noise_2d_core
// Fractal value noise over a 2-D point, one pipelined octave unit per octave
// followed by a pipelined normalizing divider.
//
//   channel   dir  data                                 handshake
//   s_axis    in   coord_x [31:0], coord_y [63:32]       tvalid/tready
//   m_axis    out  noise_value [15:0]                    tvalid/tready
//   cfg       in   cfg_index_i, cfg_data_i               cfg_valid_i/cfg_ready_o
//
// One word per cycle while the output is not stalled (7 stages per octave
// unit, 19 in the divider). Reset clears all valid bits and loads register
// defaults. A stalled output freezes the whole pipeline; input is taken in
// the same cycle the output word leaves. Config writes are always ready.
// ---------------------------------------------------------------------------
`default_nettype none

module fbm_value_noise_2d_core #(
  parameter int unsigned MAX_OCTAVES     = 8,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // coord_x, coord_y
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // noise_value
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [fbm_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [fbm_pkg::DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SUM_W  = 44 + $clog2(MAX_OCTAVES + 1);
  localparam int unsigned NORM_W = fbm_pkg::AMP_W + $clog2(MAX_OCTAVES + 1);

  fbm_pkg::cfg_t cfg_q;
  logic          en;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed         <= fbm_pkg::SEED_RST;
      cfg_q.octave_count <= fbm_pkg::CNT_RST;
      cfg_q.lacunarity   <= fbm_pkg::LAC_RST;
      cfg_q.gain         <= fbm_pkg::GAIN_RST;
    end else if (cfg_valid_i) begin
      case (fbm_pkg::cfg_idx_e'(cfg_index_i))
        fbm_pkg::CFG_SEED:   cfg_q.seed         <= cfg_data_i;
        fbm_pkg::CFG_OCTAVE: cfg_q.octave_count <= cfg_data_i[fbm_pkg::CNT_W-1:0];
        fbm_pkg::CFG_LAC:    cfg_q.lacunarity   <= cfg_data_i[fbm_pkg::FACT_W-1:0];
        fbm_pkg::CFG_GAIN:   cfg_q.gain         <= cfg_data_i[fbm_pkg::FACT_W-1:0];
        default: ;
      endcase
    end
  end

  logic                            ch_valid [MAX_OCTAVES+1];
  logic [fbm_pkg::COORD_W-1:0]     ch_x     [MAX_OCTAVES+1];
  logic [fbm_pkg::COORD_W-1:0]     ch_y     [MAX_OCTAVES+1];
  logic [fbm_pkg::FREQ_W-1:0]      ch_freq  [MAX_OCTAVES+1];
  logic [fbm_pkg::AMP_W-1:0]       ch_amp   [MAX_OCTAVES+1];
  logic signed [SUM_W-1:0]         ch_sum   [MAX_OCTAVES+1];
  logic [NORM_W-1:0]               ch_norm  [MAX_OCTAVES+1];

  assign ch_valid[0] = s_axis_tvalid;
  assign ch_x[0]     = s_axis_tdata[31:0];
  assign ch_y[0]     = s_axis_tdata[63:32];
  assign ch_freq[0]  = fbm_pkg::FREQ_ONE;
  assign ch_amp[0]   = fbm_pkg::AMP_HALF;
  assign ch_sum[0]   = '0;
  assign ch_norm[0]  = '0;

  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
    fbm_octave #(
      .OCT_IDX         (o),
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .SUM_W           (SUM_W),
      .NORM_W          (NORM_W)
    ) u_oct (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .cfg_i     (cfg_q),
      .valid_i   (ch_valid[o]),
      .coord_x_i (ch_x[o]),
      .coord_y_i (ch_y[o]),
      .freq_i    (ch_freq[o]),
      .amp_i     (ch_amp[o]),
      .sum_i     (ch_sum[o]),
      .norm_i    (ch_norm[o]),
      .valid_o   (ch_valid[o+1]),
      .coord_x_o (ch_x[o+1]),
      .coord_y_o (ch_y[o+1]),
      .freq_o    (ch_freq[o+1]),
      .amp_o     (ch_amp[o+1]),
      .sum_o     (ch_sum[o+1]),
      .norm_o    (ch_norm[o+1])
    );
  end

  fbm_div #(
    .SUM_W  (SUM_W),
    .NORM_W (NORM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ch_valid[MAX_OCTAVES]),
    .sum_i   (ch_sum[MAX_OCTAVES]),
    .norm_i  (ch_norm[MAX_OCTAVES]),
    .valid_o (m_axis_tvalid),
    .value_o (m_axis_tdata)
  );

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata) <= 16'sd16384 &&
                       $signed(m_axis_tdata) >= -16'sd16384))
    else $error("noise value out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ch_valid[1]))
    else $error("pipeline moved during stall");

  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ch_valid[MAX_OCTAVES] && cfg_q.octave_count != '0) |-> ch_norm[MAX_OCTAVES] != '0)
    else $error("zero amplitude total with octaves enabled");

endmodule

`default_nettype wire
